// ----- src/mcrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_pkg
// Shared types, action codes and constants of the multi-channel reload timer.
// ----------------------------------------------------------------------------
package mcrt_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;
    localparam logic [1:0] ACT_POLL  = 2'd3;

    // field widths
    localparam int ACT_W    = 2;
    localparam int TIDX_W   = 8;
    localparam int MS_W     = 32;
    localparam int RUNS_W   = 16;
    localparam int RATE_W   = 17;
    localparam int FIRE_W   = 3;
    localparam int PROD_W   = MS_W + RATE_W;
    localparam int CTR_W    = 6;

    // run count codes
    localparam logic [RUNS_W-1:0] RUNS_FOREVER = 16'hFFFF;
    localparam logic [RUNS_W-1:0] RUNS_NONE    = 16'h0000;

    // ms to tick conversion
    localparam int MS_PER_SEC = 1000;
    localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(MS_PER_SEC) << MS_W;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd1000;

    // divide by 1000 as a shift by 3 and a divide by 125; below saturation the
    // product is under 2^42, so x = product >> 3 is under 2^39 and
    // floor(x / 125) = (x * RECIP_125) >> 46 holds for all of them
    localparam int DIVX_LSB    = 3;
    localparam int DIVX_W      = 39;
    localparam int RECIP_W     = 40;
    localparam int RECIP_CW    = 10;
    localparam int RECIP_STEPS = 4;
    localparam int RECIP_SH    = 46;
    localparam int ACC_W       = DIVX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = 40'd562949953422;

    // poll result limit and queue depths
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = 4;
    localparam int CMD_DEPTH   = 2;

    // timers preset at reset
    localparam int NUM_INIT = 3;

    // command from front to back
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [TIDX_W-1:0] idx;
        logic [MS_W-1:0]   ticks;
        logic [RUNS_W-1:0] runs;
    } cmd_t;

    // one timer table entry
    typedef struct packed {
        logic [MS_W-1:0]   cd;
        logic [MS_W-1:0]   rl;
        logic [RUNS_W-1:0] runs;
    } entry_t;

    // one result beat
    typedef struct packed {
        logic [FIRE_W-1:0] fired;
        logic              last;
    } res_t;

    // table contents right after reset
    function automatic entry_t init_entry(input logic [TIDX_W-1:0] idx);
        entry_t e;
        e.cd   = '0;
        e.rl   = '0;
        e.runs = RUNS_NONE;
        case (idx)
            8'd0: begin
                e.cd = 32'd1;  e.rl = 32'd1;  e.runs = RUNS_FOREVER;
            end
            8'd1: begin
                e.cd = 32'd5;  e.rl = 32'd5;  e.runs = RUNS_FOREVER;
            end
            8'd2: begin
                e.cd = 32'd10; e.rl = 32'd10; e.runs = RUNS_FOREVER;
            end
            default: begin
                e.cd = '0;
            end
        endcase
        return e;
    endfunction

endpackage

// ----- src/multi_channel_reload_timer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_reload_timer
// Table of reloading countdown timers driven by tick, start, stop and poll.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries actions (tick, start, stop, poll) with a
// timer index, a period in milliseconds and a run count. The cfg channel
// writes the tick frequency, used to turn periods into ticks; write it only
// while the block is idle. Each poll sends one m_ beat per fired timer, the
// final beat of the poll with m_last set; tick, start and stop send nothing.
// Sequence: the front takes no new beat until it is done with the last; a
// tick, stop or poll goes from capture straight to the push, a start
// through 17 shift-add multiply steps, a saturation check, 4 reciprocal
// steps for the divide by 1000 and the push, skipping the divide when the
// tick count saturates. The push waits while the command queue is full.
// The back walks the timer table one entry per cycle: every entry for a
// tick or poll, only the named entry for a start or stop. A two-deep
// command queue decouples the two sides. A poll waits until the result
// queue (8 deep) is empty; a stalled receiver therefore holds back a poll
// and the commands behind it, and input stalls once the command queue fills.
// Reset: timers 0..2 come up pending with periods 1, 5 and 10 and run
// forever, the rest stopped; the tick frequency resets to 1000.
// ----------------------------------------------------------------------------
module multi_channel_reload_timer #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mcrt_pkg::RATE_W-1:0]  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mcrt_pkg::ACT_W-1:0]   s_action,
    input  logic [mcrt_pkg::TIDX_W-1:0]  s_timer_index,
    input  logic [mcrt_pkg::MS_W-1:0]    s_period_ms,
    input  logic [mcrt_pkg::RUNS_W-1:0]  s_run_count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mcrt_pkg::FIRE_W-1:0]  m_fired_timer,
    output logic                         m_last
);
    import mcrt_pkg::*;

    logic [RATE_W-1:0] tick_freq_reg;
    logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
    cmd_t              cmd_in, cmd_out;
    logic              res_push, res_full, res_empty;
    res_t              res_in, res_out;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_freq_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            tick_freq_reg <= cfg_data;
        end
    end

    // accept and convert
    mcrt_front #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_timer_index(s_timer_index),
        .s_period_ms  (s_period_ms),
        .s_run_count  (s_run_count),
        .tick_freq    (tick_freq_reg),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .cmd_full     (cmd_full)
    );

    // command queue
    mcrt_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .full   (cmd_full),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .empty  (cmd_empty)
    );

    // table execution
    mcrt_back #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_data (cmd_out),
        .cmd_empty(cmd_empty),
        .cmd_pop  (cmd_pop),
        .res_empty(res_empty),
        .res_push (res_push),
        .res_data (res_in)
    );

    // result queue, one beat per entry
    mcrt_fifo #(
        .WIDTH($bits(res_t)),
        .DEPTH(MAX_RESULTS)
    ) u_res_q (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (res_push),
        .wr_data(res_in),
        .full   (res_full),
        .rd_en  (m_ready && !res_full ? m_ready : m_ready),
        .rd_data(res_out),
        .empty  (res_empty)
    );

    assign m_valid       = !res_empty;
    assign m_fired_timer = res_out.fired;
    assign m_last        = res_out.last;

endmodule

// ----- src/mcrt_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_fifo
// Small synchronous fifo used for the command queue and the result queue.
// ----------------------------------------------------------------------------
module mcrt_fifo #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/mcrt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_front
// Accepts input beats, drops out-of-range start/stop, converts start periods
// from milliseconds to ticks and queues commands for the back end.
// ----------------------------------------------------------------------------
module mcrt_front #(
    parameter int NUM_TIMERS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mcrt_pkg::ACT_W-1:0]   s_action,
    input  logic [mcrt_pkg::TIDX_W-1:0]  s_timer_index,
    input  logic [mcrt_pkg::MS_W-1:0]    s_period_ms,
    input  logic [mcrt_pkg::RUNS_W-1:0]  s_run_count,
    input  logic [mcrt_pkg::RATE_W-1:0]  tick_freq,
    output logic                         cmd_push,
    output mcrt_pkg::cmd_t               cmd_data,
    input  logic                         cmd_full
);
    import mcrt_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_CHK  = 3'd2;
    localparam logic [2:0] F_DIV  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    logic [2:0]        state_reg;
    logic [ACT_W-1:0]  act_reg;
    logic [TIDX_W-1:0] idx_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [RUNS_W-1:0] runs_reg;
    logic [RATE_W-1:0] rate_sh_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [MS_W-1:0]   quot_reg;
    logic [CTR_W-1:0]  cnt_reg;

    logic                       in_range, accept;
    logic [PROD_W-1:0]          prod_next;
    logic [DIVX_W-1:0]          div_x;
    logic [RECIP_CW-1:0]        recip_chunk;
    logic [DIVX_W+RECIP_CW-1:0] part_prod;
    logic [ACC_W-1:0]           acc_next;

    assign s_ready  = (state_reg == F_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (s_timer_index < TIDX_W'(NUM_TIMERS));

    // shift-add multiply step, msb of rate first
    assign prod_next = {prod_reg[PROD_W-2:0], 1'b0}
                     + (rate_sh_reg[RATE_W-1] ? PROD_W'(ms_reg) : '0);

    // divide by 1000: drop 3 bits, then multiply by the reciprocal of 125,
    // one 10-bit slice of the reciprocal per step, msb slice first
    assign div_x = prod_reg[DIVX_LSB +: DIVX_W];
    always_comb begin
        case (cnt_reg)
            CTR_W'(0): recip_chunk = RECIP_125[39:30];
            CTR_W'(1): recip_chunk = RECIP_125[29:20];
            CTR_W'(2): recip_chunk = RECIP_125[19:10];
            default:   recip_chunk = RECIP_125[9:0];
        endcase
    end
    assign part_prod = div_x * recip_chunk;
    assign acc_next  = {acc_reg[ACC_W-RECIP_CW-1:0], {RECIP_CW{1'b0}}} + ACC_W'(part_prod);

    // command toward the back end
    assign cmd_push        = (state_reg == F_PUSH) && !cmd_full;
    assign cmd_data.action = act_reg;
    assign cmd_data.idx    = idx_reg;
    assign cmd_data.ticks  = quot_reg;
    assign cmd_data.runs   = runs_reg;

    // beat capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg     <= s_action;
            idx_reg     <= s_timer_index;
            ms_reg      <= s_period_ms;
            runs_reg    <= s_run_count;
            rate_sh_reg <= tick_freq;
            prod_reg    <= '0;
        end else if (state_reg == F_MUL) begin
            rate_sh_reg <= {rate_sh_reg[RATE_W-2:0], 1'b0};
            prod_reg    <= prod_next;
        end
    end

    // conversion datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            F_CHK: begin
                acc_reg  <= '0;
                quot_reg <= (prod_reg >= SAT_LIMIT) ? '1 : '0;
            end
            F_DIV: begin
                acc_reg  <= acc_next;
                quot_reg <= acc_next[RECIP_SH +: MS_W];
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    cnt_reg <= '0;
                    if (accept) begin
                        if ((s_action == ACT_START || s_action == ACT_STOP) && !in_range) begin
                            state_reg <= F_IDLE;
                        end else if (s_action == ACT_START) begin
                            state_reg <= F_MUL;
                        end else begin
                            state_reg <= F_PUSH;
                        end
                    end
                end
                F_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CTR_W'(RATE_W - 1)) begin
                        state_reg <= F_CHK;
                    end
                end
                F_CHK: begin
                    cnt_reg   <= '0;
                    state_reg <= (prod_reg >= SAT_LIMIT) ? F_PUSH : F_DIV;
                end
                F_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CTR_W'(RECIP_STEPS - 1)) begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!cmd_full) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/mcrt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrt_back
// Executes queued commands on the timer table, one entry per cycle, and
// produces poll results with the final one of each poll marked.
// ----------------------------------------------------------------------------
module mcrt_back #(
    parameter int NUM_TIMERS = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  mcrt_pkg::cmd_t cmd_data,
    input  logic           cmd_empty,
    output logic           cmd_pop,
    input  logic           res_empty,
    output logic           res_push,
    output mcrt_pkg::res_t res_data
);
    import mcrt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_WALK = 1'b1;

    // timer table
    entry_t mem [NUM_TIMERS];

    logic                  state_reg;
    cmd_t                  cmd_reg;
    logic [CNT_W-1:0]      rd_ptr_reg, rd_end_reg;
    logic                  proc_vld_reg;
    logic [IDX_W-1:0]      proc_idx_reg;
    entry_t                rd_q_reg;
    logic                  rd_init_reg;
    logic [NUM_TIMERS-1:0] pend_reg;
    logic [NUM_TIMERS-1:0] ent_vld_reg;
    logic                  held_vld_reg;
    logic [FIRE_W-1:0]     held_idx_reg;
    logic [RES_CNT_W-1:0]  fire_cnt_reg;

    logic                  start_ok, rd_go, walk_done;
    logic [IDX_W-1:0]      rd_addr;
    entry_t                cur, new_ent;
    logic                  cur_pend, new_pend, fire;
    logic [MS_W-1:0]       cd_dec;
    logic [FIRE_W-1:0]     fire_id;

    // a poll starts only with an empty result queue, so it never overflows
    assign start_ok  = (cmd_data.action != ACT_POLL) || res_empty;
    assign cmd_pop   = (state_reg == B_IDLE) && !cmd_empty && start_ok;
    assign rd_go     = (state_reg == B_WALK) && (rd_ptr_reg < rd_end_reg);
    assign rd_addr   = rd_ptr_reg[IDX_W-1:0];
    assign walk_done = (state_reg == B_WALK) && !rd_go && !proc_vld_reg;

    // entry under update, reset contents until first written
    assign cur      = rd_init_reg ? init_entry(TIDX_W'(proc_idx_reg)) : rd_q_reg;
    assign cur_pend = pend_reg[proc_idx_reg];
    assign cd_dec   = cur.cd - 1'b1;
    assign fire_id  = FIRE_W'(proc_idx_reg);

    // per-entry update
    always_comb begin
        new_ent  = cur;
        new_pend = cur_pend;
        fire     = 1'b0;
        case (cmd_reg.action)
            ACT_TICK: begin
                if (cur.runs != RUNS_NONE && cur.cd != '0) begin
                    new_ent.cd = cd_dec;
                    if (cd_dec == '0) begin
                        new_pend = 1'b1;
                    end
                end
            end
            ACT_START: begin
                new_ent.cd   = cmd_reg.ticks;
                new_ent.rl   = cmd_reg.ticks;
                new_ent.runs = cmd_reg.runs;
            end
            ACT_STOP: begin
                new_pend     = 1'b0;
                new_ent.runs = RUNS_NONE;
            end
            default: begin
                if (cur_pend) begin
                    if (cur.runs == RUNS_NONE) begin
                        new_pend   = 1'b0;
                        new_ent.cd = '0;
                    end else if (fire_cnt_reg < RES_CNT_W'(MAX_RESULTS)) begin
                        if (cur.runs != RUNS_FOREVER) begin
                            new_ent.runs = cur.runs - 1'b1;
                        end
                        new_pend   = 1'b0;
                        new_ent.cd = cur.rl;
                        fire       = 1'b1;
                    end
                end
            end
        endcase
    end

    // result beats lag one firing so the last one can be marked
    always_comb begin
        res_push       = 1'b0;
        res_data.fired = held_idx_reg;
        res_data.last  = 1'b0;
        if (proc_vld_reg && fire && held_vld_reg) begin
            res_push = 1'b1;
        end else if (walk_done && cmd_reg.action == ACT_POLL && held_vld_reg) begin
            res_push      = 1'b1;
            res_data.last = 1'b1;
        end
    end

    // table read and write-back
    always_ff @(posedge aclk) begin
        if (rd_go) begin
            rd_q_reg <= mem[rd_addr];
        end
        if (proc_vld_reg) begin
            mem[proc_idx_reg] <= new_ent;
        end
    end

    // read pipeline payload
    always_ff @(posedge aclk) begin
        if (rd_go) begin
            proc_idx_reg <= rd_addr;
            rd_init_reg  <= !ent_vld_reg[rd_addr];
        end
        if (cmd_pop) begin
            cmd_reg <= cmd_data;
        end
        if (proc_vld_reg && fire) begin
            held_idx_reg <= fire_id;
        end
    end

    // per-entry flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                pend_reg[i] <= (i < NUM_INIT);
            end
            ent_vld_reg <= '0;
        end else if (proc_vld_reg) begin
            pend_reg[proc_idx_reg]    <= new_pend;
            ent_vld_reg[proc_idx_reg] <= 1'b1;
        end
    end

    // walk control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            rd_ptr_reg   <= '0;
            rd_end_reg   <= '0;
            proc_vld_reg <= 1'b0;
            held_vld_reg <= 1'b0;
            fire_cnt_reg <= '0;
        end else begin
            proc_vld_reg <= rd_go;
            case (state_reg)
                B_IDLE: begin
                    if (cmd_pop) begin
                        state_reg    <= B_WALK;
                        held_vld_reg <= 1'b0;
                        fire_cnt_reg <= '0;
                        if (cmd_data.action == ACT_TICK || cmd_data.action == ACT_POLL) begin
                            rd_ptr_reg <= '0;
                            rd_end_reg <= CNT_W'(NUM_TIMERS);
                        end else begin
                            rd_ptr_reg <= CNT_W'(cmd_data.idx);
                            rd_end_reg <= CNT_W'(cmd_data.idx) + CNT_W'(1);
                        end
                    end
                end
                B_WALK: begin
                    if (rd_go) begin
                        rd_ptr_reg <= rd_ptr_reg + 1'b1;
                    end
                    if (proc_vld_reg && fire) begin
                        held_vld_reg <= 1'b1;
                        fire_cnt_reg <= fire_cnt_reg + 1'b1;
                    end
                    if (walk_done) begin
                        state_reg    <= B_IDLE;
                        held_vld_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
